// ----- hw/rtl/linear_blend_skinning_macros.svh -----
// Assertion macros used by the checker of this block.
`ifndef LINEAR_BLEND_SKINNING_MACROS_SVH
`define LINEAR_BLEND_SKINNING_MACROS_SVH

// Same-cycle implication, off during reset.
`define LBS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off during reset.
`define LBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication, always checked.
`define LBS_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/lbs_pkg.sv -----
`timescale 1ns / 1ps
package lbs_pkg;

   localparam int JOINTS_DEF    = 64;
   localparam int FRAC_BITS_DEF = 16;
   localparam int WEIGHT_FRAC   = 14;
   localparam int QUEUE_DEPTH   = 4;

   localparam logic [1:0] ACT_LOAD_INV   = 2'd0;
   localparam logic [1:0] ACT_LOAD_WORLD = 2'd1;
   localparam logic [1:0] ACT_LOAD_GEOM  = 2'd2;
   localparam logic [1:0] ACT_INFLUENCE  = 2'd3;

   localparam logic CFG_JOINT_COUNT = 1'b0;
   localparam logic CFG_USE_GEOM    = 1'b1;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [15:0] joint;
      logic [3:0]         element;
      logic signed [31:0] value;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
      logic signed [15:0] weight;
      logic               do_skin;
      logic               last;
   } entry_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -64'sh0000_0000_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
      logic signed [47:0] r;
      if (v > 64'sh0000_7FFF_FFFF_FFFF) begin
         r = 48'sh7FFF_FFFF_FFFF;
      end else if (v < -64'sh0000_8000_0000_0000) begin
         r = 48'sh8000_0000_0000;
      end else begin
         r = v[47:0];
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/lbs_if.sv -----
`timescale 1ns / 1ps
interface lbs_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic signed [15:0] joint;
   logic [3:0]         element;
   logic signed [31:0] element_value;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic signed [31:0] point_z;
   logic signed [15:0] weight;
   logic               last_influence;

   modport source (output valid, action, joint, element, element_value, point_x, point_y,
                   point_z, weight, last_influence, input ready);
   modport sink (input valid, action, joint, element, element_value, point_x, point_y,
                 point_z, weight, last_influence, output ready);
endinterface

interface lbs_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic signed [31:0] out_z;

   modport source (output valid, out_x, out_y, out_z, input ready);
   modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

// ----- hw/rtl/lbs_ram.sv -----
`timescale 1ns / 1ps
module lbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- hw/rtl/lbs_fifo.sv -----
`timescale 1ns / 1ps
module lbs_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  lbs_pkg::entry_type push_data,
   output logic               push_ready,
   output logic               pop_valid,
   output lbs_pkg::entry_type pop_data,
   input  logic               pop_ready
);
   localparam int PW = $clog2(lbs_pkg::QUEUE_DEPTH);

   lbs_pkg::entry_type buf_ff [lbs_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [PW:0]   cnt_ff, cnt_in;
   logic          do_push, do_pop;

   assign push_ready = (cnt_ff != (PW+1)'(lbs_pkg::QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_data   = buf_ff[rp_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wp_in  = do_push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = do_pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (PW+1)'(do_push) - (PW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         buf_ff[wp_ff] <= push_data;
      end
   end
endmodule

// ----- hw/rtl/lbs_front.sv -----
`timescale 1ns / 1ps
module lbs_front #(
   parameter int JOINTS = lbs_pkg::JOINTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [6:0]         csr_wdata,
   lbs_req_if.sink            req,
   output logic               push_valid,
   output lbs_pkg::entry_type push_data,
   input  logic               push_ready,
   output logic               use_geom
);
   logic [6:0] jcount_ff;
   logic       geom_ff;
   logic       in_range, keep;

   always_ff @(posedge clock) begin
      if (reset) begin
         jcount_ff <= '0;
         geom_ff   <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            lbs_pkg::CFG_JOINT_COUNT: jcount_ff <= csr_wdata;
            lbs_pkg::CFG_USE_GEOM:    geom_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign use_geom = geom_ff;
   assign in_range = !req.joint[15] && (req.joint < 16'(JOINTS));

   always_comb begin
      unique case (req.action)
         lbs_pkg::ACT_LOAD_INV, lbs_pkg::ACT_LOAD_WORLD: keep = in_range;
         default: keep = 1'b1;
      endcase
      push_data.action  = req.action;
      push_data.joint   = req.joint;
      push_data.element = req.element;
      push_data.value   = req.element_value;
      push_data.px      = req.point_x;
      push_data.py      = req.point_y;
      push_data.pz      = req.point_z;
      push_data.weight  = req.weight;
      push_data.do_skin = (req.weight != '0) && in_range
                          && (req.joint < {9'd0, jcount_ff});
      push_data.last    = req.last_influence;
   end

   assign push_valid = req.valid && keep;
   assign req.ready  = push_ready;
endmodule

// ----- hw/rtl/lbs_div.sv -----
`timescale 1ns / 1ps
module lbs_div #(
   parameter int FRAC_BITS = lbs_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] num,
   input  logic signed [31:0] den,
   output logic               done,
   output logic signed [31:0] quo
);
   localparam int DW = 32 + FRAC_BITS;
   localparam int CW = $clog2(DW + 1);

   logic [CW-1:0] cnt_ff, cnt_in;
   logic [31:0]   rem_ff, rem_in, den_ff, den_in;
   logic [DW-1:0] q_ff, q_in;
   logic          neg_ff, neg_in, done_ff, done_in;
   logic [32:0]   rem_sh;
   logic [31:0]   num_mag;
   logic [DW-1:0] lim_neg, q_neg;

   assign num_mag = num[31] ? 32'(-num) : 32'(num);
   assign rem_sh  = {rem_ff, q_ff[DW-1]};

   always_comb begin
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in = CW'(DW);
         rem_in = '0;
         den_in = den[31] ? 32'(-den) : 32'(den);
         q_in   = {num_mag, {FRAC_BITS{1'b0}}};
         neg_in = num[31] ^ den[31];
      end else if (cnt_ff != '0) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = 32'(rem_sh - {1'b0, den_ff});
            q_in   = {q_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[31:0];
            q_in   = {q_ff[DW-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
      neg_ff <= neg_in;
   end

   assign lim_neg = {{(DW-32){1'b0}}, 1'b1, 31'b0};
   assign q_neg   = DW'(-q_ff);

   always_comb begin
      if (!neg_ff) begin
         quo = (|q_ff[DW-1:31]) ? 32'sh7FFF_FFFF : q_ff[31:0];
      end else begin
         quo = (q_ff > lim_neg) ? 32'sh8000_0000 : q_neg[31:0];
      end
   end

   assign done = done_ff;
endmodule

// ----- hw/rtl/lbs_back.sv -----
`timescale 1ns / 1ps
module lbs_back #(
   parameter int JOINTS    = lbs_pkg::JOINTS_DEF,
   parameter int FRAC_BITS = lbs_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               use_geom,
   input  logic               pop_valid,
   input  lbs_pkg::entry_type pop_data,
   output logic               pop_ready,
   lbs_rsp_if.source          rsp
);
   localparam int AW = $clog2(JOINTS * 16);
   localparam int SW = 66 - FRAC_BITS;
   localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_RD        = 4'd1;
   localparam logic [3:0] S_MUL       = 4'd2;
   localparam logic [3:0] S_ADD       = 4'd3;
   localparam logic [3:0] S_DIV_START = 4'd4;
   localparam logic [3:0] S_DIV_WAIT  = 4'd5;
   localparam logic [3:0] S_WMUL      = 4'd6;
   localparam logic [3:0] S_WADD      = 4'd7;
   localparam logic [3:0] S_EMIT      = 4'd8;

   localparam logic [1:0] M_GEOM = 2'd0;
   localparam logic [1:0] M_MM   = 2'd1;
   localparam logic [1:0] M_SKIN = 2'd2;

   logic [3:0] state_ff, state_in;
   logic [1:0] mode_ff, mode_in;
   logic [3:0] e_ff, e_in;
   logic [1:0] k_ff, k_in;
   logic signed [SW-1:0] sum_ff, sum_in, sum_n;
   logic signed [63:0] prod_ff, prod_in, sh, wsh;
   logic signed [31:0] gm_ff [16], gm_in [16];
   logic signed [31:0] skin_ff [16], skin_in [16];
   logic signed [31:0] src_ff [3], src_in [3];
   logic signed [31:0] bind_ff [3], bind_in [3];
   logic signed [31:0] mov_ff [3], mov_in [3];
   logic signed [31:0] r_ff [4], r_in [4];
   logic signed [47:0] acc_ff [3], acc_in [3];
   logic               first_ff, first_in;
   logic signed [15:0] joint_ff, joint_in, weight_ff, weight_in;
   logic               skin_ff_en, skin_en_in, last_ff, last_in;
   logic               ov_ff, ov_in;
   logic signed [31:0] ox_ff, ox_in, oy_ff, oy_in, oz_ff, oz_in;
   logic signed [31:0] opa, opb, res, dres;
   logic               inv_we, wld_we, div_start, div_done, pop;
   logic [AW-1:0]      waddr, inv_ra, wld_ra;
   logic [31:0]        inv_rd, wld_rd;
   logic signed [31:0] div_q;

   assign pop_ready = (state_ff == S_IDLE);
   assign pop       = pop_valid && pop_ready;
   assign waddr     = AW'({pop_data.joint, pop_data.element});
   assign inv_we    = pop && (pop_data.action == lbs_pkg::ACT_LOAD_INV);
   assign wld_we    = pop && (pop_data.action == lbs_pkg::ACT_LOAD_WORLD);
   assign inv_ra    = AW'({joint_ff, e_ff[3:2], k_ff});
   assign wld_ra    = AW'({joint_ff, k_ff, e_ff[1:0]});

   lbs_ram #(.WIDTH(32), .DEPTH(JOINTS * 16)) u_inv (
      .clock(clock), .we(inv_we), .waddr(waddr), .wdata(pop_data.value),
      .raddr(inv_ra), .rdata(inv_rd));

   lbs_ram #(.WIDTH(32), .DEPTH(JOINTS * 16)) u_wld (
      .clock(clock), .we(wld_we), .waddr(waddr), .wdata(pop_data.value),
      .raddr(wld_ra), .rdata(wld_rd));

   lbs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(r_ff[e_ff[1:0]]),
      .den(r_ff[3]), .done(div_done), .quo(div_q));

   always_comb begin
      if (state_ff == S_WMUL) begin
         opa = mov_ff[e_ff[1:0]];
         opb = 32'(weight_ff);
      end else if (mode_ff == M_MM) begin
         opa = inv_rd;
         opb = wld_rd;
      end else begin
         if (k_ff == 2'd3) begin
            opa = ONE;
         end else if (mode_ff == M_GEOM) begin
            opa = src_ff[k_ff];
         end else begin
            opa = bind_ff[k_ff];
         end
         opb = (mode_ff == M_GEOM) ? gm_ff[{k_ff, e_ff[1:0]}] : skin_ff[{k_ff, e_ff[1:0]}];
      end
   end

   assign sh    = prod_ff >>> FRAC_BITS;
   assign wsh   = prod_ff >>> lbs_pkg::WEIGHT_FRAC;
   assign sum_n = sum_ff + SW'(sh);
   assign res   = lbs_pkg::sat32(64'(sum_n));
   assign dres  = div_start ? r_ff[e_ff[1:0]] : div_q;

   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      e_in       = e_ff;
      k_in       = k_ff;
      sum_in     = sum_ff;
      prod_in    = prod_ff;
      gm_in      = gm_ff;
      skin_in    = skin_ff;
      src_in     = src_ff;
      bind_in    = bind_ff;
      mov_in     = mov_ff;
      r_in       = r_ff;
      acc_in     = acc_ff;
      first_in   = first_ff;
      joint_in   = joint_ff;
      weight_in  = weight_ff;
      skin_en_in = skin_ff_en;
      last_in    = last_ff;
      ov_in      = ov_ff && !rsp.ready;
      ox_in      = ox_ff;
      oy_in      = oy_ff;
      oz_in      = oz_ff;
      div_start  = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (pop && pop_data.action == lbs_pkg::ACT_LOAD_GEOM) begin
               gm_in[pop_data.element] = pop_data.value;
            end else if (pop && pop_data.action == lbs_pkg::ACT_INFLUENCE) begin
               joint_in   = pop_data.joint;
               weight_in  = pop_data.weight;
               skin_en_in = pop_data.do_skin;
               last_in    = pop_data.last;
               src_in[0]  = pop_data.px;
               src_in[1]  = pop_data.py;
               src_in[2]  = pop_data.pz;
               e_in       = '0;
               k_in       = '0;
               sum_in     = '0;
               if (first_ff && use_geom) begin
                  first_in = 1'b0;
                  mode_in  = M_GEOM;
                  state_in = S_RD;
               end else begin
                  if (first_ff) begin
                     first_in   = 1'b0;
                     bind_in[0] = pop_data.px;
                     bind_in[1] = pop_data.py;
                     bind_in[2] = pop_data.pz;
                  end
                  mode_in = M_MM;
                  if (pop_data.do_skin) begin
                     state_in = S_RD;
                  end else if (pop_data.last) begin
                     state_in = S_EMIT;
                  end
               end
            end
         end
         S_RD: state_in = S_MUL;
         S_MUL: begin
            prod_in  = opa * opb;
            state_in = S_ADD;
         end
         S_ADD: begin
            state_in = S_RD;
            if (k_ff == 2'd3) begin
               k_in   = '0;
               sum_in = '0;
               if (mode_ff == M_MM) begin
                  skin_in[e_ff] = res;
                  if (e_ff == 4'd15) begin
                     mode_in = M_SKIN;
                     e_in    = '0;
                  end else begin
                     e_in = e_ff + 1'b1;
                  end
               end else begin
                  r_in[e_ff[1:0]] = res;
                  if (e_ff == 4'd3) begin
                     e_in     = '0;
                     state_in = S_DIV_START;
                  end else begin
                     e_in = e_ff + 1'b1;
                  end
               end
            end else begin
               k_in   = k_ff + 1'b1;
               sum_in = sum_n;
            end
         end
         S_DIV_START, S_DIV_WAIT: begin
            if (state_ff == S_DIV_START && r_ff[3] != '0 && r_ff[3] != ONE) begin
               div_start = 1'b1;
               state_in  = S_DIV_WAIT;
            end else if (state_ff == S_DIV_START || div_done) begin
               if (mode_ff == M_GEOM) begin
                  bind_in[e_ff[1:0]] = (state_ff == S_DIV_START) ? r_ff[e_ff[1:0]] : dres;
               end else begin
                  mov_in[e_ff[1:0]] = (state_ff == S_DIV_START) ? r_ff[e_ff[1:0]] : dres;
               end
               if (e_ff == 4'd2) begin
                  e_in = '0;
                  if (mode_ff == M_SKIN) begin
                     state_in = S_WMUL;
                  end else begin
                     mode_in = M_MM;
                     if (skin_ff_en) begin
                        state_in = S_RD;
                     end else if (last_ff) begin
                        state_in = S_EMIT;
                     end else begin
                        state_in = S_IDLE;
                     end
                  end
               end else begin
                  e_in     = e_ff + 1'b1;
                  state_in = S_DIV_START;
               end
            end
         end
         S_WMUL: begin
            prod_in  = opa * opb;
            state_in = S_WADD;
         end
         S_WADD: begin
            acc_in[e_ff[1:0]] = lbs_pkg::sat48(64'(acc_ff[e_ff[1:0]]) + wsh);
            if (e_ff == 4'd2) begin
               e_in     = '0;
               state_in = last_ff ? S_EMIT : S_IDLE;
            end else begin
               e_in     = e_ff + 1'b1;
               state_in = S_WMUL;
            end
         end
         S_EMIT: begin
            if (!ov_ff || rsp.ready) begin
               ov_in    = 1'b1;
               ox_in    = lbs_pkg::sat32(64'(acc_ff[0]));
               oy_in    = lbs_pkg::sat32(64'(acc_ff[1]));
               oz_in    = lbs_pkg::sat32(64'(acc_ff[2]));
               acc_in   = '{default: '0};
               first_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ov_ff    <= 1'b0;
         first_ff <= 1'b1;
         acc_ff   <= '{default: '0};
         bind_ff  <= '{default: '0};
      end else begin
         state_ff <= state_in;
         ov_ff    <= ov_in;
         first_ff <= first_in;
         acc_ff   <= acc_in;
         bind_ff  <= bind_in;
      end
      mode_ff    <= mode_in;
      e_ff       <= e_in;
      k_ff       <= k_in;
      sum_ff     <= sum_in;
      prod_ff    <= prod_in;
      gm_ff      <= gm_in;
      skin_ff    <= skin_in;
      src_ff     <= src_in;
      mov_ff     <= mov_in;
      r_ff       <= r_in;
      joint_ff   <= joint_in;
      weight_ff  <= weight_in;
      skin_ff_en <= skin_en_in;
      last_ff    <= last_in;
      ox_ff      <= ox_in;
      oy_ff      <= oy_in;
      oz_ff      <= oz_in;
   end

   assign rsp.valid = ov_ff;
   assign rsp.out_x = ox_ff;
   assign rsp.out_y = oy_ff;
   assign rsp.out_z = oz_ff;
endmodule

// ----- hw/rtl/linear_blend_skinning.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Handshake            Payload
// req_ch    in   valid/ready          action, joint, element, element_value, point, weight, last
// rsp_ch    out  valid/ready          out_x, out_y, out_z
// csr_*     in   csr_we (no ready)    csr_index, csr_wdata
//
// Loads are written in the back end's idle state. An influence runs its multiplies on the
// one shared 32x32 multiplier as read, multiply and add steps (weighting as multiply and
// add) for the geometry-bind transform, skin matrix, point transform and weighting, plus
// divisions by w. Sync reset; matrix tables need no clearing. A 4-entry queue lets input
// keep arriving while the back end works; a held result stalls only the emitting item.
module linear_blend_skinning #(
   parameter int JOINTS    = lbs_pkg::JOINTS_DEF,
   parameter int FRAC_BITS = lbs_pkg::FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [6:0] csr_wdata,
   lbs_req_if.sink    req_ch,
   lbs_rsp_if.source  rsp_ch
);
   lbs_pkg::entry_type push_data, pop_data;
   logic push_valid, push_ready, pop_valid, pop_ready, use_geom;

   lbs_front #(.JOINTS(JOINTS)) u_front (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .req(req_ch), .push_valid(push_valid),
      .push_data(push_data), .push_ready(push_ready), .use_geom(use_geom));

   lbs_fifo u_fifo (
      .clock(clock), .reset(reset), .push_valid(push_valid), .push_data(push_data),
      .push_ready(push_ready), .pop_valid(pop_valid), .pop_data(pop_data),
      .pop_ready(pop_ready));

   lbs_back #(.JOINTS(JOINTS), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock(clock), .reset(reset), .use_geom(use_geom), .pop_valid(pop_valid),
      .pop_data(pop_data), .pop_ready(pop_ready), .rsp(rsp_ch));
endmodule

// ----- hw/rtl/lbs_checker.sv -----
`timescale 1ns / 1ps
`include "linear_blend_skinning_macros.svh"
module lbs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_x
);
   `LBS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped")
   `LBS_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_x), "rsp changed")
   `LBS_ASSERT_ALWAYS(a_rst_rsp, clock, reset, !rsp_valid, "rsp valid after reset")
   `LBS_ASSERT_ALWAYS(a_rst_req, clock, reset, req_ready, "req not ready after reset")
endmodule

bind linear_blend_skinning lbs_checker u_lbs_checker (
   .clock(clock), .reset(reset), .req_ready(req_ch.ready), .rsp_valid(rsp_ch.valid),
   .rsp_ready(rsp_ch.ready), .rsp_x(rsp_ch.out_x));

// ----- bench/tb_linear_blend_skinning.sv -----
`timescale 1ns / 1ps
module tb_linear_blend_skinning;

   localparam int JOINTS    = lbs_pkg::JOINTS_DEF;
   localparam int FRAC_BITS = lbs_pkg::FRAC_BITS_DEF;
   localparam int SETTLE    = 3000;
   localparam int HOLD_LONG = 20000;

   typedef int    mat_type[16];
   typedef int    vec3_type[3];
   typedef longint acc3_type[3];

   typedef struct {
      bit [1:0]         action;
      bit signed [15:0] joint;
      bit [3:0]         element;
      bit signed [31:0] value;
      bit signed [31:0] px;
      bit signed [31:0] py;
      bit signed [31:0] pz;
      bit signed [15:0] weight;
      bit               last;
   } req_type;

   typedef struct {
      int x;
      int y;
      int z;
   } pos_type;

   typedef struct {
      req_type item;
      bit      fixed;
      pos_type want;
   } row_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic csr_index;
   logic [6:0] csr_wdata;

   lbs_req_if req_ch();
   lbs_rsp_if rsp_ch();

   linear_blend_skinning i_dut (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch)
   );

   // predictor state
   int       inv_tab[JOINTS*16];
   int       wld_tab[JOINTS*16];
   int       geom_mat[16];
   vec3_type bind_pt;
   acc3_type blend_acc;
   bit       vertex_open;
   int       joint_limit;
   bit       geom_on;

   // which matrix entries hold data
   bit [15:0] inv_ok[JOINTS];
   bit [15:0] wld_ok[JOINTS];

   pos_type pos_q[$];
   int      errors;
   int      mismatches;
   bit      snd_gaps;
   bit      rsp_gaps;
   bit      hold_request;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #80ms;
      $display("linear_blend_skinning test failed");
      $finish;
   end

   function automatic int clamp32(input longint v);
      if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (v < -64'sh8000_0000) return 32'sh8000_0000;
      return int'(v);
   endfunction

   function automatic longint clamp48(input longint v);
      if (v > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
      if (v < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
      return v;
   endfunction

   function automatic longint qmul(input int a, input int b);
      return (longint'(a) * longint'(b)) >>> FRAC_BITS;
   endfunction

   function automatic void mat_prod(input mat_type a, input mat_type b, output mat_type r);
      longint s;
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            s = 0;
            for (int k = 0; k < 4; k++) s += qmul(a[i*4+k], b[k*4+j]);
            r[i*4+j] = clamp32(s);
         end
      end
   endfunction

   function automatic void move_point(input mat_type m, input vec3_type p,
                                      output vec3_type o);
      int     h[4];
      longint one;
      one = longint'(1) << FRAC_BITS;
      for (int c = 0; c < 4; c++)
         h[c] = clamp32(qmul(p[0], m[c]) + qmul(p[1], m[4+c]) + qmul(p[2], m[8+c])
                        + longint'(m[12+c]));
      for (int c = 0; c < 3; c++) begin
         if (h[3] != 0 && longint'(h[3]) != one)
            o[c] = clamp32((longint'(h[c]) * one) / longint'(h[3]));
         else
            o[c] = h[c];
      end
   endfunction

   function automatic bit skin_step(input req_type it, output pos_type res);
      mat_type  a, b, s;
      vec3_type p, mv;
      int       base;
      res = '{0, 0, 0};
      if (it.action == lbs_pkg::ACT_LOAD_INV || it.action == lbs_pkg::ACT_LOAD_WORLD) begin
         if (it.joint >= 0 && it.joint < JOINTS) begin
            base = int'(it.joint) * 16 + int'(it.element);
            if (it.action == lbs_pkg::ACT_LOAD_INV) inv_tab[base] = it.value;
            else wld_tab[base] = it.value;
         end
         return 1'b0;
      end
      if (it.action == lbs_pkg::ACT_LOAD_GEOM) begin
         geom_mat[it.element] = it.value;
         return 1'b0;
      end
      if (!vertex_open) begin
         p = '{it.px, it.py, it.pz};
         if (geom_on) move_point(geom_mat, p, bind_pt);
         else bind_pt = p;
         vertex_open = 1'b1;
      end
      if (it.weight != 0 && it.joint >= 0 && it.joint < joint_limit && it.joint < JOINTS)
      begin
         base = int'(it.joint) * 16;
         for (int e = 0; e < 16; e++) begin
            a[e] = inv_tab[base+e];
            b[e] = wld_tab[base+e];
         end
         mat_prod(a, b, s);
         move_point(s, bind_pt, mv);
         for (int c = 0; c < 3; c++)
            blend_acc[c] = clamp48(blend_acc[c] + ((longint'(it.weight) * longint'(mv[c]))
                                                   >>> lbs_pkg::WEIGHT_FRAC));
      end
      if (!it.last) return 1'b0;
      res = '{clamp32(blend_acc[0]), clamp32(blend_acc[1]), clamp32(blend_acc[2])};
      blend_acc = '{0, 0, 0};
      vertex_open = 1'b0;
      return 1'b1;
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 20);
      return $urandom_range(50, 300);
   endfunction

   function automatic int small_rand(input int k);
      return int'($urandom_range(0, 2 * k)) - k;
   endfunction

   function automatic int elem_val(input int mode, input int e);
      if (mode == 2) return int'($urandom);
      if (e == 3 || e == 7 || e == 11) return (mode == 1) ? small_rand(256) : 0;
      if (e == 15) begin
         if (mode == 1 && $urandom_range(0, 3) == 0) return 0;
         return (mode == 1) ? 65536 + small_rand(4096) : 65536;
      end
      if (e == 0 || e == 5 || e == 10) return 65536 + small_rand(16384);
      if (e >= 12) return small_rand(20 << 16);
      return small_rand(16384);
   endfunction

   function automatic int coord_rand();
      if ($urandom_range(0, 3) == 0) return int'($urandom);
      return small_rand(100 << 16);
   endfunction

   task automatic transfer_item(input req_type it, input bit fixed, input pos_type want);
      pos_type res;
      int      g;
      req_ch.valid          <= 1'b1;
      req_ch.action         <= it.action;
      req_ch.joint          <= it.joint;
      req_ch.element        <= it.element;
      req_ch.element_value  <= it.value;
      req_ch.point_x        <= it.px;
      req_ch.point_y        <= it.py;
      req_ch.point_z        <= it.pz;
      req_ch.weight         <= it.weight;
      req_ch.last_influence <= it.last;
      do @(posedge clock); while (!req_ch.ready);
      if (it.joint >= 0 && it.joint < JOINTS) begin
         if (it.action == lbs_pkg::ACT_LOAD_INV) inv_ok[it.joint][it.element] = 1'b1;
         if (it.action == lbs_pkg::ACT_LOAD_WORLD) wld_ok[it.joint][it.element] = 1'b1;
      end
      if (skin_step(it, res)) pos_q.push_back(fixed ? want : res);
      g = snd_gaps ? gap_len() : 0;
      if (g > 0) begin
         req_ch.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic send(input req_type it);
      transfer_item(it, 1'b0, '{0, 0, 0});
   endtask

   task automatic load_matrix(input bit [1:0] act, input int j, input int mode);
      req_type it;
      for (int e = 0; e < 16; e++) begin
         it = '{act, 16'(j), 4'(e), elem_val(mode, e), int'($urandom), int'($urandom),
                int'($urandom), 16'($urandom), 1'($urandom)};
         send(it);
      end
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (pos_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input int data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 7'(data);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == lbs_pkg::CFG_JOINT_COUNT) joint_limit = data & 8'h7F;
      else geom_on = data[0];
   endtask

   function automatic bit joint_ready(input int j);
      return j >= 0 && j < JOINTS && (&inv_ok[j]) && (&wld_ok[j]);
   endfunction

   function automatic req_type random_item(input bit last);
      req_type it;
      int      r, j;
      it = '{lbs_pkg::ACT_INFLUENCE, 16'($urandom), 4'($urandom), int'($urandom),
             coord_rand(), coord_rand(), coord_rand(), 16'($urandom_range(0, 16384)), last};
      if ($urandom_range(0, 4) == 0) it.weight = 16'($urandom);
      r = $urandom_range(0, 99);
      if (r < 10) begin
         // load mixed into the stream
         case ($urandom_range(0, 3))
            0: it.action = lbs_pkg::ACT_LOAD_GEOM;
            1: begin
               it.action = $urandom_range(0, 1) ? lbs_pkg::ACT_LOAD_INV
                                                : lbs_pkg::ACT_LOAD_WORLD;
               it.joint  = $urandom_range(0, 1) ? 16'(-$urandom_range(1, 32768))
                                                : 16'($urandom_range(JOINTS, 32767));
            end
            default: begin
               it.action = $urandom_range(0, 1) ? lbs_pkg::ACT_LOAD_INV
                                                : lbs_pkg::ACT_LOAD_WORLD;
               it.joint  = 16'($urandom_range(0, 7));
               it.value  = elem_val($urandom_range(0, 2), it.element);
            end
         endcase
         return it;
      end
      j = $urandom_range(0, 7);
      if (r < 75 && joint_ready(j) && j < joint_limit) begin
         it.joint = 16'(j);
         return it;
      end
      case ($urandom_range(0, 2))
         0: it.joint = 16'(-$urandom_range(1, 32768));
         1: it.joint = 16'($urandom_range(joint_limit, 32767));
         default: it.weight = 16'sd0;
      endcase
      return it;
   endfunction

   task automatic random_phase(input int count, input int pause_at, input int hold_at);
      int      left;
      req_type it;
      left = 0;
      for (int n = 0; n < count; n++) begin
         if (n == hold_at) hold_request = 1'b1;
         if (n == pause_at) begin
            req_ch.valid <= 1'b0;
            while (pos_q.size() != 0) @(posedge clock);
         end
         if (left == 0) left = $urandom_range(1, 4);
         it = random_item(left == 1);
         if (it.action == lbs_pkg::ACT_INFLUENCE) left--;
         send(it);
      end
   endtask

   function automatic void report(input string what, input int got, input int want);
      errors++;
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch %s: expected %h, got %h", what, want, got);
   endfunction

   // result side
   initial begin
      int      idle_left, stall_left;
      pos_type want;
      idle_left  = 0;
      stall_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (pos_q.size() == 0) begin
               report("unexpected transfer", rsp_ch.out_x, 0);
            end else begin
               want = pos_q.pop_front();
               if (rsp_ch.out_x !== want.x) report("out_x", rsp_ch.out_x, want.x);
               if (rsp_ch.out_y !== want.y) report("out_y", rsp_ch.out_y, want.y);
               if (rsp_ch.out_z !== want.z) report("out_z", rsp_ch.out_z, want.z);
            end
         end
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = HOLD_LONG;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!rsp_gaps) begin
            rsp_ch.ready <= 1'b1;
         end else if (idle_left > 0) begin
            idle_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) idle_left = gap_len();
         end
      end
   end

   row_type dir_rows[16];

   initial begin
      int jc_set[6]   = '{64, 0, 8, 1, 64, 5};
      int geom_set[6] = '{0, 1, 1, 0, 1, 0};
      pos_type zero;
      zero = '{0, 0, 0};
      // joint_count is 0 after reset, so every influence below blends nothing
      dir_rows = '{
         '{'{lbs_pkg::ACT_INFLUENCE, 16'sd0, 4'd0, 32'sd0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
             32'sh7FFF_FFFF, 16'sd16384, 1'b1}, 1'b1, zero},
         '{'{lbs_pkg::ACT_INFLUENCE, -16'sd32768, 4'd15, -32'sd1, 32'sh8000_0000,
             32'sh8000_0000, 32'sh8000_0000, -16'sd32768, 1'b1}, 1'b1, zero},
         '{'{lbs_pkg::ACT_LOAD_INV, -16'sd1, 4'd3, 32'sh1234_5678, 0, 0, 0, 0, 1'b1},
           1'b0, zero},
         '{'{lbs_pkg::ACT_LOAD_WORLD, 16'sd64, 4'd7, -32'sd7, 0, 0, 0, 0, 1'b1}, 1'b0, zero},
         '{'{lbs_pkg::ACT_LOAD_INV, 16'sd32767, 4'd15, 32'sh7FFF_FFFF, -1, -1, -1, -1, 1'b0},
           1'b0, zero},
         '{'{lbs_pkg::ACT_LOAD_WORLD, -16'sd32768, 4'd0, 32'sh8000_0000, 0, 0, 0, 0, 1'b0},
           1'b0, zero},
         '{'{lbs_pkg::ACT_LOAD_GEOM, 16'sh5A5A, 4'd15, 32'sh7FFF_FFFF, 0, 0, 0, 0, 1'b1},
           1'b0, zero},
         '{'{lbs_pkg::ACT_LOAD_GEOM, -16'sd1, 4'd0, 32'sh8000_0000, 0, 0, 0, 0, 1'b0},
           1'b0, zero},
         '{'{lbs_pkg::ACT_LOAD_INV, 16'sd63, 4'd15, -32'sd1, 0, 0, 0, 0, 1'b0}, 1'b0, zero},
         '{'{lbs_pkg::ACT_LOAD_WORLD, 16'sd0, 4'd0, 32'sh0001_0000, 0, 0, 0, 0, 1'b0},
           1'b0, zero},
         '{'{lbs_pkg::ACT_INFLUENCE, 16'sd0, 4'd0, 32'sd0, 32'sd1, 32'sd2, 32'sd3, 16'sd0,
             1'b0}, 1'b0, zero},
         '{'{lbs_pkg::ACT_INFLUENCE, 16'sd63, 4'd5, 32'sd0, 32'sd9, 32'sd9, 32'sd9,
             16'sd32767, 1'b1}, 1'b1, zero},
         '{'{lbs_pkg::ACT_INFLUENCE, 16'sd1, 4'd15, -32'sd1, -32'sd1, -32'sd1, -32'sd1,
             -16'sd1, 1'b0}, 1'b0, zero},
         '{'{lbs_pkg::ACT_INFLUENCE, 16'sd32767, 4'd10, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
             16'sd32767, 1'b1}, 1'b1, zero},
         '{'{lbs_pkg::ACT_INFLUENCE, -16'sd5, 4'd1, 32'sd0, 32'sh0001_0000, 32'sd0, 32'sd0,
             16'sd16384, 1'b1}, 1'b1, zero},
         '{'{lbs_pkg::ACT_INFLUENCE, 16'sd7, 4'd2, 32'sd0, -32'sd1, 32'sh7FFF_FFFF, 32'sd0,
             16'sd0, 1'b1}, 1'b1, zero}
      };
      inv_tab     = '{default: 0};
      wld_tab     = '{default: 0};
      geom_mat    = '{default: 0};
      bind_pt     = '{0, 0, 0};
      blend_acc   = '{0, 0, 0};
      vertex_open = 1'b0;
      joint_limit = 0;
      geom_on     = 1'b0;
      inv_ok      = '{default: '0};
      wld_ok      = '{default: '0};
      errors      = 0;
      mismatches  = 0;
      hold_request = 1'b0;
      snd_gaps    = 1'b1;
      rsp_gaps    = 1'b1;

      reset     = 1'b1;
      csr_we    = 1'b0;
      csr_index = lbs_pkg::CFG_JOINT_COUNT;
      csr_wdata = '0;
      req_ch.valid          = 1'b0;
      req_ch.action         = lbs_pkg::ACT_LOAD_INV;
      req_ch.joint          = '0;
      req_ch.element        = '0;
      req_ch.element_value  = '0;
      req_ch.point_x        = '0;
      req_ch.point_y        = '0;
      req_ch.point_z        = '0;
      req_ch.weight         = '0;
      req_ch.last_influence = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) transfer_item(dir_rows[i].item, dir_rows[i].fixed,
                                          dir_rows[i].want);

      for (int j = 0; j < 8; j++) begin
         load_matrix(lbs_pkg::ACT_LOAD_INV, j, j % 3);
         load_matrix(lbs_pkg::ACT_LOAD_WORLD, j, (j + 1) % 3);
      end
      load_matrix(lbs_pkg::ACT_LOAD_GEOM, 0, $urandom_range(0, 2));

      for (int ph = 0; ph < 6; ph++) begin
         drain();
         write_reg(lbs_pkg::CFG_JOINT_COUNT, jc_set[ph]);
         write_reg(lbs_pkg::CFG_USE_GEOM, geom_set[ph]);
         snd_gaps = (ph != 4);
         rsp_gaps = (ph != 4);
         random_phase(210, (ph == 3) ? 100 : -1, (ph == 1) ? 60 : -1);
      end

      req_ch.valid <= 1'b0;
      while (pos_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (errors == 0 && pos_q.size() == 0) begin
         $display("linear_blend_skinning test passed");
      end else begin
         $display("linear_blend_skinning test failed");
      end
      $finish;
   end

endmodule
